>>> design/rde_pkg.sv
// ----------------------------------------------------------------------------
// rde_pkg: shared constants, types and helpers of the radix digit emitter
// Alphabet lookup and check, divider request/response types, register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package rde_pkg;

  // Sizes
  localparam int MAX_RADIX  = 16;
  localparam int MAX_DIGITS = 32;
  localparam int VALUE_W    = 32;
  localparam int SYM_W      = 8;
  localparam int RADIX_W    = $clog2(MAX_RADIX + 1);
  localparam int DIGIT_W    = $clog2(MAX_RADIX);
  localparam int ALPHA_W    = 64;
  localparam int DADDR_W    = $clog2(MAX_DIGITS);
  localparam int DCNT_W     = $clog2(MAX_DIGITS + 1);
  localparam int CFG_IDX_W  = 2;

  // Divider: quotient bits resolved per cycle, and passes per division
  localparam int DIV_STEPS  = 8;
  localparam int DIV_PASSES = VALUE_W / DIV_STEPS;
  localparam int DIV_PCNT_W = $clog2(DIV_PASSES);

  // Character codes
  localparam logic [SYM_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [SYM_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [SYM_W-1:0] CH_LOWEST = 8'd32;
  localparam logic [SYM_W-1:0] CH_HIGHEST = 8'd126;
  localparam logic [SYM_W-1:0] CH_NONE   = 8'd0;
  localparam logic [RADIX_W-1:0] MIN_RADIX = RADIX_W'(2);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RADIX_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

  // Reset values of the registers: radix 10, alphabet "0123456789"
  localparam logic [RADIX_W-1:0] RST_RADIX_SIZE   = RADIX_W'(10);
  localparam logic [ALPHA_W-1:0] RST_SYMBOLS_LOW  = 64'h3736353433323130;
  localparam logic [ALPHA_W-1:0] RST_SYMBOLS_HIGH = 64'h0000000000003938;

  // Divider start request
  typedef struct packed {
    logic               start;
    logic [VALUE_W-1:0] dividend;
    logic [RADIX_W-1:0] divisor;
  } div_req_t;

  // Divider result, valid while done is high
  typedef struct packed {
    logic               busy;
    logic               done;
    logic [VALUE_W-1:0] quot;
    logic [DIGIT_W-1:0] rem;
  } div_rsp_t;

  // Pick one alphabet symbol out of the two alphabet words
  function automatic logic [SYM_W-1:0] alphabet_byte(
    input logic [ALPHA_W-1:0] lo,
    input logic [ALPHA_W-1:0] hi,
    input logic [DIGIT_W-1:0] idx
  );
    logic [ALPHA_W-1:0] word;
    word = idx[DIGIT_W-1] ? hi : lo;
    return word[idx[DIGIT_W-2:0]*SYM_W +: SYM_W];
  endfunction

  // Check the symbols in use: printable, no sign characters, no repeats
  function automatic logic alphabet_valid(
    input logic [RADIX_W-1:0] n,
    input logic [ALPHA_W-1:0] lo,
    input logic [ALPHA_W-1:0] hi
  );
    logic              ok;
    logic [SYM_W-1:0]  ci;
    logic [SYM_W-1:0]  cj;
    ok = (n >= MIN_RADIX) && (n <= RADIX_W'(MAX_RADIX));
    for (int i = 0; i < MAX_RADIX; i++) begin
      ci = alphabet_byte(lo, hi, DIGIT_W'(i));
      if (RADIX_W'(i) < n) begin
        if (ci < CH_LOWEST || ci > CH_HIGHEST || ci == CH_PLUS || ci == CH_MINUS) begin
          ok = 1'b0;
        end
        for (int j = i + 1; j < MAX_RADIX; j++) begin
          cj = alphabet_byte(lo, hi, DIGIT_W'(j));
          if (RADIX_W'(j) < n && cj == ci) begin
            ok = 1'b0;
          end
        end
      end
    end
    return ok;
  endfunction

endpackage

`default_nettype wire

>>> design/rde_div.sv
// ----------------------------------------------------------------------------
// rde_div: iterative divider by the radix
// Restoring shift-subtract over the 32-bit dividend, DIV_STEPS quotient bits
// per cycle while busy; done pulses once after the last pass.
// ----------------------------------------------------------------------------
`default_nettype none

module rde_div (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire rde_pkg::div_req_t req,
  output rde_pkg::div_rsp_t     rsp
);
  import rde_pkg::*;

  logic                  busy_r;
  logic                  done_r;
  logic [DIV_PCNT_W-1:0] pass_r;
  logic [VALUE_W-1:0]    work_r;
  logic [DIGIT_W-1:0]    rem_r;
  logic [RADIX_W-1:0]    divisor_r;

  logic [VALUE_W-1:0]    work_nxt;
  logic [DIGIT_W-1:0]    rem_nxt;
  logic [VALUE_W-1:0]    w;
  logic [DIGIT_W-1:0]    r;
  logic [DIGIT_W:0]      t;

  // Resolve DIV_STEPS quotient bits; the partial remainder stays below the divisor
  always_comb begin
    w = work_r;
    r = rem_r;
    t = '0;
    for (int k = 0; k < DIV_STEPS; k++) begin
      t = {r, w[VALUE_W-1]};
      w = {w[VALUE_W-2:0], 1'b0};
      if ((DIGIT_W+1)'(divisor_r) <= t) begin
        t    = t - (DIGIT_W+1)'(divisor_r);
        w[0] = 1'b1;
      end
      r = t[DIGIT_W-1:0];
    end
    work_nxt = w;
    rem_nxt  = r;
  end

  // Load on start, advance one pass per cycle while busy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      pass_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r    <= 1'b1;
        pass_r    <= '0;
        work_r    <= req.dividend;
        rem_r     <= '0;
        divisor_r <= req.divisor;
      end else if (busy_r) begin
        work_r <= work_nxt;
        rem_r  <= rem_nxt;
        pass_r <= pass_r + DIV_PCNT_W'(1);
        if (pass_r == DIV_PCNT_W'(DIV_PASSES - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = work_r;
  assign rsp.rem  = rem_r;

endmodule

`default_nettype wire

>>> design/radix_digit_emitter.sv
// ----------------------------------------------------------------------------
// radix_digit_emitter: signed integer to text in a configured radix
// Steps: check the alphabet, then one division per digit in the shared divider,
//   one sign step, then a fetch and an emit step per digit beat.
// Throughput: one value at a time; in_ready returns after the last beat is
//   loaded, also for zero or error.
// The per-digit divider pass count sets the conversion time.
// Reset: synchronous active low; registers return to radix 10, "0123456789".
// ----------------------------------------------------------------------------
`default_nettype none

module radix_digit_emitter (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // Input value
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic signed [rde_pkg::VALUE_W-1:0]   in_value,
  // Result characters
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [rde_pkg::SYM_W-1:0]                 out_symbol,
  output logic                                      out_last,
  output logic                                      out_bad_alphabet,
  // Register writes
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [rde_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [rde_pkg::ALPHA_W-1:0]          cfg_data
);
  import rde_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_SIGN,
    ST_FETCH,
    ST_EMIT
  } state_t;

  state_t               state_r;
  logic [RADIX_W-1:0]   radix_size_r;
  logic [ALPHA_W-1:0]   symbols_low_r;
  logic [ALPHA_W-1:0]   symbols_high_r;
  logic [VALUE_W-1:0]   value_r;
  logic                 neg_r;
  logic [DCNT_W-1:0]    count_r;
  logic                 out_valid_r;
  logic [SYM_W-1:0]     out_symbol_r;
  logic                 out_last_r;
  logic                 out_bad_r;
  logic [DIGIT_W-1:0]   digit_mem [MAX_DIGITS];
  logic [DIGIT_W-1:0]   rd_digit_r;

  div_req_t             div_req;
  div_rsp_t             div_rsp;
  logic                 alpha_ok;
  logic                 out_free;
  logic                 last_digit;
  logic                 mem_we;
  logic [VALUE_W-1:0]   magnitude;
  logic [DCNT_W-1:0]    count_dec;

  // Shared divider
  rde_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign alpha_ok   = alphabet_valid(radix_size_r, symbols_low_r, symbols_high_r);
  assign out_free   = !out_valid_r || out_ready;
  assign magnitude  = value_r[VALUE_W-1] ? (~value_r + VALUE_W'(1)) : value_r;
  assign last_digit = (div_rsp.quot == '0) || (count_r == DCNT_W'(MAX_DIGITS - 1));
  assign mem_we     = (state_r == ST_DIV) && div_rsp.done;
  assign count_dec  = count_r - DCNT_W'(1);

  // Start the divider on a nonzero value, restart it on each quotient
  always_comb begin
    div_req.start    = ((state_r == ST_CHECK) && alpha_ok && (value_r != '0)) ||
                       (mem_we && !last_digit);
    div_req.dividend = (state_r == ST_CHECK) ? magnitude : div_rsp.quot;
    div_req.divisor  = radix_size_r;
  end

  // Sequencer, register file and output beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      radix_size_r   <= RST_RADIX_SIZE;
      symbols_low_r  <= RST_SYMBOLS_LOW;
      symbols_high_r <= RST_SYMBOLS_HIGH;
      count_r        <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_RADIX_SIZE:   radix_size_r   <= cfg_data[RADIX_W-1:0];
          REG_SYMBOLS_LOW:  symbols_low_r  <= cfg_data;
          REG_SYMBOLS_HIGH: symbols_high_r <= cfg_data;
          default: ;
        endcase
      end

      // Drop the held beat once taken; a load below overrides
      if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            value_r <= in_value;
            state_r <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (!alpha_ok) begin
            if (out_free) begin
              out_valid_r  <= 1'b1;
              out_symbol_r <= CH_NONE;
              out_last_r   <= 1'b1;
              out_bad_r    <= 1'b1;
              state_r      <= ST_IDLE;
            end
          end else if (value_r == '0) begin
            if (out_free) begin
              out_valid_r  <= 1'b1;
              out_symbol_r <= alphabet_byte(symbols_low_r, symbols_high_r, '0);
              out_last_r   <= 1'b1;
              out_bad_r    <= 1'b0;
              state_r      <= ST_IDLE;
            end
          end else begin
            neg_r   <= value_r[VALUE_W-1];
            count_r <= '0;
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            count_r <= count_r + DCNT_W'(1);
            if (last_digit) begin
              state_r <= ST_SIGN;
            end
          end
        end
        ST_SIGN: begin
          if (!neg_r) begin
            state_r <= ST_FETCH;
          end else if (out_free) begin
            out_valid_r  <= 1'b1;
            out_symbol_r <= CH_MINUS;
            out_last_r   <= 1'b0;
            out_bad_r    <= 1'b0;
            state_r      <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          count_r <= count_dec;
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_symbol_r <= alphabet_byte(symbols_low_r, symbols_high_r, rd_digit_r);
            out_last_r   <= (count_r == '0);
            out_bad_r    <= 1'b0;
            state_r      <= (count_r == '0) ? ST_IDLE : ST_FETCH;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Digit store: remainders land least significant first, read back in reverse
  always_ff @(posedge clk) begin
    if (mem_we) begin
      digit_mem[count_r[DADDR_W-1:0]] <= div_rsp.rem;
    end
    if (state_r == ST_FETCH) begin
      rd_digit_r <= digit_mem[count_dec[DADDR_W-1:0]];
    end
  end

  assign in_ready         = (state_r == ST_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_symbol       = out_symbol_r;
  assign out_last         = out_last_r;
  assign out_bad_alphabet = out_bad_r;

endmodule

`default_nettype wire

>>> design/rde_chk.sv
// ----------------------------------------------------------------------------
// rde_chk: port-level checks of the radix digit emitter
// Watches the top level's ports only; attached by the bind at the end.
// ----------------------------------------------------------------------------
`default_nettype none

module rde_chk (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_valid,
  input wire logic                               in_ready,
  input wire logic                               out_valid,
  input wire logic                               out_ready,
  input wire logic [rde_pkg::SYM_W-1:0]          out_symbol,
  input wire logic                               out_last,
  input wire logic                               out_bad_alphabet
);
  import rde_pkg::*;

  // Hold a stalled beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_symbol) &&
      $stable(out_last) && $stable(out_bad_alphabet))
    else $error("rde_chk: stalled result beat changed");

  // An error beat stands alone with a zero symbol
  a_bad_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_alphabet |-> out_last && out_symbol == CH_NONE)
    else $error("rde_chk: error beat not final or symbol not zero");

  // A value is in work the cycle after it is taken
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("rde_chk: input ready right after a beat");

  // No result right out of reset
  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("rde_chk: result or busy after reset");

endmodule

bind radix_digit_emitter rde_chk u_rde_chk (.*);

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the radix digit emitter
// Drives signed values through the input channel under several digit
// alphabets (decimal, binary, hex, random printable sets and broken sets),
// predicts every character beat in a scoreboard and checks the result
// channel beat by beat, with random idle gaps on both sides.
// ----------------------------------------------------------------------------

module tb_top;
  import rde_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int RANDOM_SETTINGS = 12;
  localparam int VALUES_PER_SETTING = 42;

  // One expected character beat
  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
    logic             bad;
  } char_beat_t;

  // Ways to break an otherwise good alphabet
  typedef enum int {
    SHORT_RADIX, LONG_RADIX, UNPRINTABLE, PLUS_SIGN, MINUS_SIGN, REPEATED
  } alpha_fault_t;

  // Mirror of the registers plus the queue of characters still owed
  class text_ledger;
    logic [RADIX_W-1:0] radix;
    logic [127:0]       alpha;
    char_beat_t         owed_chars[$];
    int                 mismatches;
    int                 beats_checked;
    int                 values_seen;
    int                 rejected_values;
    int                 longest_text;

    function new();
      radix = RST_RADIX_SIZE;
      alpha = {RST_SYMBOLS_HIGH, RST_SYMBOLS_LOW};
    endfunction

    function void mirror_write(logic [CFG_IDX_W-1:0] idx, logic [ALPHA_W-1:0] data);
      case (idx)
        REG_RADIX_SIZE:   radix = data[RADIX_W-1:0];
        REG_SYMBOLS_LOW:  alpha[63:0] = data;
        REG_SYMBOLS_HIGH: alpha[127:64] = data;
        default: ;
      endcase
    endfunction

    function logic [SYM_W-1:0] glyph(logic [3:0] d);
      return alpha[d*8 +: 8];
    endfunction

    // Printable, no sign characters, no repeats among the symbols in use
    function bit alphabet_usable();
      logic [SYM_W-1:0] c;
      if (radix < 2 || radix > MAX_RADIX) return 1'b0;
      for (int i = 0; i < radix; i++) begin
        c = glyph(i[3:0]);
        if (c < CH_LOWEST || c > CH_HIGHEST || c == CH_PLUS || c == CH_MINUS) return 1'b0;
        for (int j = i + 1; j < radix; j++) begin
          if (glyph(j[3:0]) == c) return 1'b0;
        end
      end
      return 1'b1;
    endfunction

    // Work out the text of one accepted value
    function void render_value(logic signed [VALUE_W-1:0] v);
      logic [VALUE_W-1:0] mag;
      logic [3:0]         digits[$];
      int unsigned        base;
      int                 len;
      values_seen++;
      if (!alphabet_usable()) begin
        owed_chars.push_back('{CH_NONE, 1'b1, 1'b1});
        rejected_values++;
        return;
      end
      if (v == 0) begin
        owed_chars.push_back('{glyph(4'd0), 1'b1, 1'b0});
        return;
      end
      base = radix;
      mag = v[VALUE_W-1] ? (32'd0 - v) : v;
      while (mag != 0) begin
        digits.push_front(4'(mag % base));
        mag = mag / base;
      end
      len = digits.size();
      if (v[VALUE_W-1]) begin
        owed_chars.push_back('{CH_MINUS, 1'b0, 1'b0});
        len++;
      end
      foreach (digits[k]) begin
        owed_chars.push_back('{glyph(digits[k]), k == digits.size() - 1, 1'b0});
      end
      if (len > longest_text) longest_text = len;
    endfunction

    // Compare one result beat against the oldest owed character
    function void match_char(logic [SYM_W-1:0] sym, logic last, logic bad);
      char_beat_t want;
      beats_checked++;
      if (owed_chars.size() == 0) begin
        $error("unexpected result beat: symbol 'h%02h last %0d bad_alphabet %0d",
               sym, last, bad);
        mismatches++;
        return;
      end
      want = owed_chars.pop_front();
      if (sym !== want.symbol) begin
        $error("symbol: expected 'h%02h, got 'h%02h", want.symbol, sym);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, last);
        mismatches++;
      end
      if (bad !== want.bad) begin
        $error("bad_alphabet: expected %0d, got %0d", want.bad, bad);
        mismatches++;
      end
    endfunction

    function int pending_count();
      return owed_chars.size();
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic signed [VALUE_W-1:0]   in_value = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [SYM_W-1:0]            out_symbol;
  logic                        out_last;
  logic                        out_bad_alphabet;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [ALPHA_W-1:0]          cfg_data = '0;

  text_ledger  ledger = new();
  bit          steady = 1'b0;
  int unsigned ready_hold = 0;
  int          settings_used = 0;

  radix_digit_emitter uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_symbol       (out_symbol),
    .out_last         (out_last),
    .out_bad_alphabet (out_bad_alphabet),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #2 clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 92) return $urandom_range(1, 3);
    else return $urandom_range(8, 40);
  endfunction

  // Stall the result channel at random, except in steady stretches
  always @(negedge clk) begin
    if (ready_hold != 0) begin
      out_ready <= 1'b0;
      ready_hold--;
    end else begin
      out_ready <= 1'b1;
      if (!steady) ready_hold = pick_gap();
    end
  end

  // Note each accepted value and check each accepted character
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) ledger.render_value(in_value);
    if (rst_n && out_valid && out_ready)
      ledger.match_char(out_symbol, out_last, out_bad_alphabet);
  end

  // Offer one value after an idle gap; return at the edge that takes it
  task send_value(input logic signed [VALUE_W-1:0] v);
    int unsigned gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold off the sender until every owed character has come back
  task pause_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (ledger.pending_count() != 0) @(posedge clk);
  endtask

  task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ALPHA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    ledger.mirror_write(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Load size and both alphabet words once the block has gone quiet
  task load_alphabet(input logic [4:0] n, input logic [127:0] alpha);
    logic [ALPHA_W-1:0] size_word;
    pause_until_drained();
    size_word = {$urandom(), $urandom()};
    size_word[4:0] = n;
    write_reg(REG_RADIX_SIZE, size_word);
    write_reg(REG_SYMBOLS_LOW, alpha[63:0]);
    write_reg(REG_SYMBOLS_HIGH, alpha[127:64]);
    settings_used++;
  endtask

  // Distinct printable symbols in use, random bytes in the unused slots
  function automatic logic [127:0] make_alphabet(int n);
    logic [127:0]     a;
    bit               taken[256];
    logic [SYM_W-1:0] c;
    a = {$urandom(), $urandom(), $urandom(), $urandom()};
    for (int i = 0; i < n; i++) begin
      do c = 8'($urandom_range(32, 126));
      while (taken[c] || c == CH_PLUS || c == CH_MINUS);
      taken[c] = 1'b1;
      a[i*8 +: 8] = c;
    end
    return a;
  endfunction

  // Break a good alphabet in one random way
  function automatic void corrupt_alphabet(inout logic [4:0] n, inout logic [127:0] a);
    alpha_fault_t fault;
    int           p;
    int           q;
    fault = alpha_fault_t'($urandom_range(0, 5));
    p = $urandom_range(0, n - 1);
    case (fault)
      SHORT_RADIX: n = 5'($urandom_range(0, 1));
      LONG_RADIX:  n = 5'($urandom_range(17, 31));
      UNPRINTABLE: a[p*8 +: 8] = $urandom_range(0, 1) ? 8'($urandom_range(0, 31))
                                                        : 8'($urandom_range(127, 255));
      PLUS_SIGN:   a[p*8 +: 8] = CH_PLUS;
      MINUS_SIGN:  a[p*8 +: 8] = CH_MINUS;
      default: begin
        p = $urandom_range(1, n - 1);
        q = $urandom_range(0, p - 1);
        a[p*8 +: 8] = a[q*8 +: 8];
      end
    endcase
  endfunction

  // Mix of full-range, short, extreme and radix-power values
  function automatic logic signed [VALUE_W-1:0] pick_value(int unsigned base);
    int unsigned               r;
    longint                    p;
    logic signed [VALUE_W-1:0] v;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      v = $urandom();
    end else if (r < 55) begin
      v = $urandom_range(0, 300);
    end else if (r < 65) begin
      case ($urandom_range(0, 4))
        0: v = 0;
        1: v = 1;
        2: v = -1;
        3: v = 32'h7FFF_FFFF;
        default: v = 32'h8000_0000;
      endcase
    end else if (r < 80) begin
      p = 1;
      repeat ($urandom_range(1, 31)) begin
        if (p * base <= 64'h7FFF_FFFF) p = p * base;
      end
      p = p + $urandom_range(0, 2) - 1;
      v = p[31:0];
    end else begin
      v = $urandom() >> $urandom_range(0, 31);
    end
    if (r >= 40 && $urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  initial begin
    logic [4:0]   n;
    logic [127:0] alpha;
    logic [127:0] hex_alpha;
    logic [127:0] dec_alpha;
    bit           broken;

    hex_alpha = {64'h4645444342413938, 64'h3736353433323130};
    dec_alpha = {RST_SYMBOLS_HIGH, RST_SYMBOLS_LOW};

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Reset alphabet: zero, unit values and both extremes
    send_value(0);
    send_value(1);
    send_value(-1);
    send_value(32'h7FFF_FFFF);
    send_value(32'h8000_0000);

    // Binary: most negative value gives the longest text
    load_alphabet(5'd2, {$urandom(), $urandom(), $urandom(), 16'($urandom()), 16'h3130});
    send_value(32'h8000_0000);
    send_value(5);

    // Full sixteen-symbol alphabet
    load_alphabet(5'd16, hex_alpha);
    send_value(-1);
    send_value(32'hDEAD_BEEF);
    send_value(32'h8000_0000);

    // Rejected alphabets; the zero value must still see the rejection
    load_alphabet(5'd1, dec_alpha);
    send_value(0);
    load_alphabet(5'd0, dec_alpha);
    send_value(123);
    load_alphabet(5'd17, hex_alpha);
    send_value(-5);
    load_alphabet(5'd31, hex_alpha);
    send_value(32'h7FFF_FFFF);
    alpha = dec_alpha;
    alpha[5*8 +: 8] = CH_PLUS;
    load_alphabet(5'd10, alpha);
    send_value(42);
    alpha = dec_alpha;
    alpha[2*8 +: 8] = CH_MINUS;
    load_alphabet(5'd10, alpha);
    send_value(-42);
    alpha = dec_alpha;
    alpha[3*8 +: 8] = 8'd31;
    load_alphabet(5'd10, alpha);
    send_value(7);
    alpha = dec_alpha;
    alpha[9*8 +: 8] = 8'd127;
    load_alphabet(5'd10, alpha);
    send_value(8);
    alpha = dec_alpha;
    alpha[9*8 +: 8] = 8'h30;
    load_alphabet(5'd10, alpha);
    send_value(9);
    alpha = hex_alpha;
    alpha[15*8 +: 8] = 8'h41;
    load_alphabet(5'd16, alpha);
    send_value(1);

    // Edge printable symbols, sign bytes parked in unused slots
    load_alphabet(5'd3, {64'h2B2B2B2B2B2B2B2B, 64'h2D2D2D2D2D787E20});
    send_value(-7);
    send_value(0);

    // Random alphabets, extremes first, some of them broken
    for (int ph = 0; ph < RANDOM_SETTINGS; ph++) begin
      n = (ph == 0) ? 5'd2 : (ph == 1) ? 5'd16 : 5'($urandom_range(2, 16));
      alpha = make_alphabet(n);
      broken = (ph >= 2) && ($urandom_range(0, 99) < 15);
      if (broken) corrupt_alphabet(n, alpha);
      load_alphabet(n, alpha);
      if (ph == 0 || $urandom_range(0, 3) == 0)
        write_reg(REG_UNUSED, {$urandom(), $urandom()});
      steady = ($urandom_range(0, 3) == 0);
      repeat (VALUES_PER_SETTING) begin
        if ($urandom_range(0, 99) < 4) pause_until_drained();
        send_value(pick_value((n >= 2 && n <= 16) ? n : 10));
      end
      steady = 1'b0;
    end

    // Drain, then give stray beats time to show up
    pause_until_drained();
    repeat (400) @(posedge clk);

    $display("Covered %0d values under %0d alphabet settings, %0d of them rejected.",
             ledger.values_seen, settings_used, ledger.rejected_values);
    $display("Checked %0d character beats; longest rendered text %0d characters.",
             ledger.beats_checked, ledger.longest_text);
    if (ledger.mismatches == 0 && ledger.pending_count() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
